// ===== rtl/core/bo2c_pkg.sv =====
// Shared constants, result slot type and frame size helpers for the 2x2 opening checker.
// Depends on nothing; the top level, the assertion module and the testbench import it.
package bo2c_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int DIM_W     = 7;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int POS_W     = 6;
    localparam int CNT_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int RES_MAX   = 4;
    localparam int SLOT_W    = $clog2(RES_MAX);

    localparam int EXT_A = (DIM_W > COL_W) ? DIM_W : COL_W;
    localparam int EXT_W = ((EXT_A > ROW_W) ? EXT_A : ROW_W) + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [DIM_W-1:0]     DIM_RESET        = DIM_W'(64);

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             is_anchor;
        logic             uncovered;
        logic             frame_end;
    } slot_t;

    function automatic logic [COL_W-1:0] col_last(input logic [DIM_W-1:0] dim);
        logic [EXT_W-1:0] d;
        d = EXT_W'(dim);
        if (d == '0)
            return '0;
        else if (d > EXT_W'(MAX_WIDTH))
            return COL_W'(MAX_WIDTH - 1);
        else
            return COL_W'(d - EXT_W'(1));
    endfunction

    function automatic logic [ROW_W-1:0] row_last(input logic [DIM_W-1:0] dim);
        logic [EXT_W-1:0] d;
        d = EXT_W'(dim);
        if (d == '0)
            return '0;
        else if (d > EXT_W'(MAX_HEIGHT))
            return ROW_W'(MAX_HEIGHT - 1);
        else
            return ROW_W'(d - EXT_W'(1));
    endfunction

endpackage

// ===== rtl/core/bo2c_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the pixel and anchor line buffers.
module bo2c_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/binary_opening_2x2_checker.sv =====
// Channel   Handshake              Payload
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
// pixels    pix_valid / pix_stall  pixel
// results   res_valid / res_stall  row, col, is_anchor, uncovered, last_of_run,
//                                  frame_end, frame_ok, anchor_count
//
// A pixel that causes at most one result is taken every cycle while the result side
// does not stall. A pixel that causes several results keeps the result register busy
// until all have left, so a later pixel with results waits; results go through a_, then b_.
// Reset clears the counters and sets both frame sizes to 64; the line buffers are
// not cleared. A stall on the result side reaches pix_stall once both registers are full.
//
// Top level of the streaming 2x2 opening checker.
// Depends on bo2c_pkg and bo2c_ram.
module binary_opening_2x2_checker
    import bo2c_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  logic                 pixel,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [POS_W-1:0]     row,
    output logic [POS_W-1:0]     col,
    output logic                 is_anchor,
    output logic                 uncovered,
    output logic                 last_of_run,
    output logic                 frame_end,
    output logic                 frame_ok,
    output logic [CNT_W-1:0]     anchor_count
);

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    logic             cfg_hit;

    logic             pix_accept;
    logic             res_accept;
    logic [COL_W-1:0] col_cnt_reg;
    logic [COL_W-1:0] col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg;
    logic [ROW_W-1:0] row_cnt_next;

    logic             a_valid_reg;
    logic             a_valid_next;
    logic             a_pixel_reg;
    logic [COL_W-1:0] a_col_reg;
    logic [ROW_W-1:0] a_row_reg;
    logic             a_bypass_reg;
    logic             a_bypass_pix_reg;

    logic             pix_q;
    logic             anc_q;

    logic             ul_reg;
    logic             lp_reg;
    logic             ap_reg;
    logic             tp_reg;
    logic [CNT_W-1:0] total_reg;
    logic             seen_reg;

    logic               b_valid_reg;
    slot_t              b_slots_reg [RES_MAX];
    logic [SLOT_W-1:0]  b_last_reg;
    logic [SLOT_W-1:0]  b_idx_reg;
    logic [CNT_W-1:0]   b_total_reg;
    logic               b_ok_reg;

    logic             row_ge1;
    logic             row_ge2;
    logic             col_ge1;
    logic             col_end;
    logic             row_end;
    logic             up_right;
    logic             anc;
    logic             t1;
    logic [ROW_W-1:0] row_up;
    logic [COL_W-1:0] col_left;
    logic [RES_MAX-1:0] cond;
    slot_t            res_slot [RES_MAX];
    slot_t            slots_next [RES_MAX];
    logic [SLOT_W:0]  fill;
    logic             any_unc;
    logic             has_res;
    logic [CNT_W-1:0] total_inc;
    logic             bundle_free;
    logic             a_move;
    logic             frame_done;
    slot_t            sel;

    assign w_last     = col_last(frame_width_reg);
    assign h_last     = row_last(frame_height_reg);
    assign cfg_ready  = 1'b1;
    assign cfg_hit    = cfg_valid && (cfg_index == CFG_FRAME_WIDTH
                                      || cfg_index == CFG_FRAME_HEIGHT);
    assign pix_accept = pix_valid && !pix_stall;
    assign res_accept = b_valid_reg && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_RESET;
            frame_height_reg <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data;
            end
            else if (cfg_index == CFG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_hit)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (pix_accept)
        begin
            if (col_cnt_reg == w_last)
            begin
                col_cnt_next = '0;
                row_cnt_next = (row_cnt_reg == h_last) ? '0 : row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    bo2c_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_pix_line (
        .clk   (clk),
        .we    (a_move),
        .waddr (a_col_reg),
        .wdata (a_pixel_reg),
        .re    (pix_accept),
        .raddr (col_cnt_reg),
        .rdata (pix_q)
    );

    bo2c_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_anc_line (
        .clk   (clk),
        .we    (a_move && row_ge1 && col_ge1),
        .waddr (col_left),
        .wdata (anc),
        .re    (pix_accept),
        .raddr (col_cnt_reg - COL_W'(1)),
        .rdata (anc_q)
    );

    assign row_ge1  = a_row_reg != '0;
    assign row_ge2  = row_ge1 && (a_row_reg != ROW_W'(1));
    assign col_ge1  = a_col_reg != '0;
    assign col_end  = a_col_reg == w_last;
    assign row_end  = a_row_reg == h_last;
    assign row_up   = a_row_reg - ROW_W'(1);
    assign col_left = a_col_reg - COL_W'(1);
    assign up_right = a_bypass_reg ? a_bypass_pix_reg : pix_q;
    assign anc      = row_ge1 && col_ge1 && ul_reg && up_right && lp_reg && a_pixel_reg;
    assign t1       = row_ge2 && col_ge1 && anc_q;

    assign cond[0] = row_ge1 && col_ge1;
    assign cond[1] = row_ge1 && col_end;
    assign cond[2] = row_end && col_ge1;
    assign cond[3] = row_end && col_end;

    always_comb
    begin
        res_slot[0] = '{row: POS_W'(row_up), col: POS_W'(col_left), is_anchor: anc,
                        uncovered: ul_reg && !(anc || ap_reg || t1 || tp_reg),
                        frame_end: 1'b0};
        res_slot[1] = '{row: POS_W'(row_up), col: POS_W'(w_last), is_anchor: 1'b0,
                        uncovered: up_right && !(anc || t1), frame_end: 1'b0};
        res_slot[2] = '{row: POS_W'(a_row_reg), col: POS_W'(col_left), is_anchor: 1'b0,
                        uncovered: lp_reg && !(anc || ap_reg), frame_end: 1'b0};
        res_slot[3] = '{row: POS_W'(a_row_reg), col: POS_W'(w_last), is_anchor: 1'b0,
                        uncovered: a_pixel_reg && !anc, frame_end: 1'b1};
    end

    always_comb
    begin
        fill    = '0;
        any_unc = 1'b0;
        for (int s = 0; s < RES_MAX; s++)
        begin
            slots_next[s] = '0;
        end
        for (int r = 0; r < RES_MAX; r++)
        begin
            if (cond[r])
            begin
                slots_next[fill[SLOT_W-1:0]] = res_slot[r];
                fill = fill + (SLOT_W + 1)'(1);
                any_unc = any_unc || res_slot[r].uncovered;
            end
        end
    end

    assign has_res     = |cond;
    assign total_inc   = (anc && total_reg != '1) ? total_reg + CNT_W'(1) : total_reg;
    assign frame_done  = row_end && col_end;
    assign bundle_free = !b_valid_reg || (res_accept && b_idx_reg == b_last_reg);
    assign a_move      = a_valid_reg && (!has_res || bundle_free);
    assign pix_stall   = a_valid_reg && !a_move;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (pix_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            a_pixel_reg      <= pixel;
            a_col_reg        <= col_cnt_reg;
            a_row_reg        <= row_cnt_reg;
            a_bypass_reg     <= a_move && (a_col_reg == col_cnt_reg);
            a_bypass_pix_reg <= a_pixel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ul_reg    <= 1'b0;
            lp_reg    <= 1'b0;
            ap_reg    <= 1'b0;
            tp_reg    <= 1'b0;
            total_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (cfg_hit)
        begin
            ul_reg    <= 1'b0;
            lp_reg    <= 1'b0;
            total_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (a_move)
        begin
            ul_reg    <= col_end ? 1'b0 : up_right;
            lp_reg    <= col_end ? 1'b0 : a_pixel_reg;
            ap_reg    <= anc;
            tp_reg    <= t1;
            total_reg <= frame_done ? '0 : total_inc;
            seen_reg  <= frame_done ? 1'b0 : (seen_reg || any_unc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_idx_reg   <= '0;
        end
        else if (a_move && has_res)
        begin
            b_valid_reg <= 1'b1;
            b_idx_reg   <= '0;
        end
        else if (res_accept)
        begin
            if (b_idx_reg == b_last_reg)
            begin
                b_valid_reg <= 1'b0;
            end
            else
            begin
                b_idx_reg <= b_idx_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move && has_res)
        begin
            b_slots_reg <= slots_next;
            b_last_reg  <= SLOT_W'(fill - (SLOT_W + 1)'(1));
            b_total_reg <= total_inc;
            b_ok_reg    <= !(seen_reg || any_unc);
        end
    end

    assign sel          = b_slots_reg[b_idx_reg];
    assign res_valid    = b_valid_reg;
    assign row          = sel.row;
    assign col          = sel.col;
    assign is_anchor    = sel.is_anchor;
    assign uncovered    = sel.uncovered;
    assign last_of_run  = b_idx_reg == b_last_reg;
    assign frame_end    = sel.frame_end;
    assign frame_ok     = sel.frame_end && b_ok_reg;
    assign anchor_count = b_total_reg;

endmodule

// ===== rtl/core/bo2c_checker.sv =====
// Port-level assertions for the 2x2 opening checker, bound to its top level.
// Depends on bo2c_pkg and binary_opening_2x2_checker.
module bo2c_checker
    import bo2c_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [DIM_W-1:0]     cfg_data,
    input logic                 pix_valid,
    input logic                 pix_stall,
    input logic                 pixel,
    input logic                 res_valid,
    input logic                 res_stall,
    input logic [POS_W-1:0]     row,
    input logic [POS_W-1:0]     col,
    input logic                 is_anchor,
    input logic                 uncovered,
    input logic                 last_of_run,
    input logic                 frame_end,
    input logic                 frame_ok,
    input logic [CNT_W-1:0]     anchor_count
);

    // The pixel side only waits while results are queued for the result side.
    a_stall_needs_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid
    ) else $error("pixel side stalled with no result pending");

    // Results of one pixel follow each other with no gap in res_valid and share one anchor count.
    a_run_continues: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !last_of_run
        |=> res_valid && anchor_count == $past(anchor_count)
    ) else $error("run of results broken or anchor count changed inside a run");

    // A frame verdict comes only with the last result of the frame.
    a_ok_at_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && frame_ok |-> frame_end && last_of_run
    ) else $error("frame_ok shown away from the end of a frame");

    a_res_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_stall
        |=> res_valid && $stable(row) && $stable(col) && $stable(last_of_run)
    ) else $error("stalled result changed");

endmodule

bind binary_opening_2x2_checker bo2c_checker u_bo2c_checker (.*);

// ===== dv/tb_binary_opening_2x2_checker.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the streaming 2x2 binary opening checker.
// Holds its own pixel-accurate predictor; depends on bo2c_pkg and the block's RTL.
module tb_binary_opening_2x2_checker;
    import bo2c_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             is_anchor;
        logic             uncovered;
        logic             last_of_run;
        logic             frame_end;
        logic             frame_ok;
        logic [CNT_W-1:0] anchor_count;
    } opening_result_t;

    typedef struct {
        bit value;
        bit settle_first;
    } pixel_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    logic                 pixel = 1'b0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [POS_W-1:0]     row;
    logic [POS_W-1:0]     col;
    logic                 is_anchor;
    logic                 uncovered;
    logic                 last_of_run;
    logic                 frame_end;
    logic                 frame_ok;
    logic [CNT_W-1:0]     anchor_count;

    binary_opening_2x2_checker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pixel        (pixel),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .row          (row),
        .col          (col),
        .is_anchor    (is_anchor),
        .uncovered    (uncovered),
        .last_of_run  (last_of_run),
        .frame_end    (frame_end),
        .frame_ok     (frame_ok),
        .anchor_count (anchor_count)
    );

    // Predictor state.
    logic [DIM_W-1:0] frame_cols_reg = DIM_RESET;
    logic [DIM_W-1:0] frame_rows_reg = DIM_RESET;
    bit pix_line [MAX_WIDTH];
    bit anc_prev [MAX_WIDTH];
    bit anc_cur [MAX_WIDTH];
    bit left_px;
    bit upleft_px;
    int col_n;
    int row_n;
    int anchors;
    bit any_uncovered;
    opening_result_t step_batch[$];
    opening_result_t results_due[$];

    // Stimulus and handshake bookkeeping.
    pixel_req_t pixel_q[$];
    bit img [MAX_HEIGHT][MAX_WIDTH];
    bit pix_took;
    bit sender_steady;
    bit receiver_steady;
    int gap_left;
    int stall_left;
    int hold_left;
    int hold_req;

    int mismatches;
    int pixels_sent;
    int results_seen;
    int cfg_writes;
    int frames_closed;
    int frames_clean;
    int anchors_seen;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int lim);
        if (v == '0)
            return 1;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    function automatic int pick_run();
        if ($urandom_range(99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit anc_one_up(input int c);
        if (c < 0 || row_n < 1)
            return 1'b0;
        return anc_cur[c];
    endfunction

    function automatic bit anc_two_up(input int c);
        if (c < 0 || row_n < 2)
            return 1'b0;
        return anc_prev[c];
    endfunction

    task automatic restart_frame();
        col_n = 0;
        row_n = 0;
        anchors = 0;
        any_uncovered = 1'b0;
        left_px = 1'b0;
        upleft_px = 1'b0;
    endtask

    task automatic add_result(input int r, input int c, input bit pix, input bit anc,
                              input bit other, input bit fend);
        opening_result_t res;
        res.row = POS_W'(r);
        res.col = POS_W'(c);
        res.is_anchor = anc;
        res.uncovered = pix && !(anc || other);
        if (res.uncovered)
            any_uncovered = 1'b1;
        res.last_of_run = 1'b0;
        res.frame_end = fend;
        res.frame_ok = fend && !any_uncovered;
        res.anchor_count = CNT_W'(anchors);
        step_batch.push_back(res);
    endtask

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
        if (idx == CFG_FRAME_WIDTH)
        begin
            frame_cols_reg = d;
            restart_frame();
        end
        else if (idx == CFG_FRAME_HEIGHT)
        begin
            frame_rows_reg = d;
            restart_frame();
        end
    endtask

    task automatic predict_opening(input bit p);
        int w;
        int h;
        int i;
        int j;
        bit up_right;
        bit up_left;
        bit a;
        bit other;
        w = eff_dim(frame_cols_reg, MAX_WIDTH);
        h = eff_dim(frame_rows_reg, MAX_HEIGHT);
        step_batch.delete();
        if (col_n >= w || row_n >= h)
            restart_frame();
        i = row_n;
        j = col_n;
        up_right = pix_line[j];
        up_left = upleft_px;
        if (i >= 1)
        begin
            if (j >= 1)
            begin
                a = up_left & up_right & left_px & p;
                anc_cur[j-1] = a;
                if (a && anchors < 4095)
                    anchors++;
                other = anc_one_up(j - 2) | anc_two_up(j - 1) | anc_two_up(j - 2);
                add_result(i - 1, j - 1, up_left, a, other, 1'b0);
            end
            if (j == w - 1)
            begin
                anc_cur[w-1] = 1'b0;
                other = anc_one_up(w - 2) | anc_two_up(w - 1) | anc_two_up(w - 2);
                add_result(i - 1, w - 1, up_right, 1'b0, other, 1'b0);
            end
        end
        if (i == h - 1)
        begin
            if (j >= 1)
            begin
                other = anc_one_up(j - 1) | anc_one_up(j - 2);
                add_result(i, j - 1, left_px, 1'b0, other, 1'b0);
            end
            if (j == w - 1)
            begin
                other = anc_one_up(w - 1) | anc_one_up(w - 2);
                add_result(i, w - 1, p, 1'b0, other, 1'b1);
            end
        end
        if (step_batch.size() > 0)
            step_batch[step_batch.size()-1].last_of_run = 1'b1;
        foreach (step_batch[k])
            results_due.push_back(step_batch[k]);

        upleft_px = up_right;
        pix_line[j] = p;
        left_px = p;
        j++;
        if (j == w)
        begin
            j = 0;
            anc_prev = anc_cur;
            left_px = 1'b0;
            upleft_px = 1'b0;
            i++;
            if (i == h)
            begin
                i = 0;
                anchors = 0;
                any_uncovered = 1'b0;
            end
        end
        col_n = j;
        row_n = i;
    endtask

    task automatic check_result();
        opening_result_t got;
        opening_result_t want;
        got = '{row, col, is_anchor, uncovered, last_of_run, frame_end, frame_ok,
                anchor_count};
        results_seen++;
        if (results_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with none expected: row %0d col %0d", $realtime,
                         got.row, got.col);
            return;
        end
        want = results_due.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: exp row %0d col %0d anc %0b unc %0b lor %0b end %0b ok %0b n %0d",
                         $realtime, want.row, want.col, want.is_anchor, want.uncovered,
                         want.last_of_run, want.frame_end, want.frame_ok, want.anchor_count);
                $display("%0t: got row %0d col %0d anc %0b unc %0b lor %0b end %0b ok %0b n %0d",
                         $realtime, got.row, got.col, got.is_anchor, got.uncovered,
                         got.last_of_run, got.frame_end, got.frame_ok, got.anchor_count);
            end
        end
        else if (want.frame_end)
        begin
            frames_closed++;
            if (want.frame_ok)
                frames_clean++;
        end
        if (got.is_anchor === 1'b1)
            anchors_seen++;
    endtask

    always @(posedge clk)
    begin : watch_ports
        if (!rst_n)
        begin
            pix_took = 1'b0;
        end
        else
        begin
            pix_took = pix_valid && !pix_stall;
            if (cfg_valid && cfg_ready)
            begin
                apply_config(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (pix_took)
            begin
                predict_opening(pixel);
                pixels_sent++;
            end
            if (res_valid && !res_stall)
                check_result();
        end
    end

    always @(negedge clk)
    begin : drive_pixels
        bit next_valid;
        bit next_pixel;
        pixel_req_t req;
        next_valid = 1'b0;
        next_pixel = pixel;
        if (rst_n)
        begin
            if (pix_valid && !pix_took)
            begin
                next_valid = 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pixel_q.size() > 0 &&
                     !(pixel_q[0].settle_first && results_due.size() > 0))
            begin
                req = pixel_q.pop_front();
                next_valid = 1'b1;
                next_pixel = req.value;
                if (sender_steady || $urandom_range(99) < 65)
                    gap_left = 0;
                else
                    gap_left = pick_run();
            end
        end
        pix_valid <= next_valid;
        pixel <= next_pixel;
    end

    always @(negedge clk)
    begin : drive_stall
        bit next_stall;
        next_stall = 1'b0;
        if (rst_n)
        begin
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_stall = 1'b1;
            end
            else if (!receiver_steady && $urandom_range(99) < 25)
            begin
                stall_left = pick_run() - 1;
                next_stall = 1'b1;
            end
        end
        res_stall <= next_stall;
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || pix_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_bits(input int n, input logic [63:0] bits);
        for (int k = n - 1; k >= 0; k--)
            pixel_q.push_back('{value: bits[k], settle_first: 1'b0});
    endtask

    task automatic build_frame(input int w, input int h);
        int style;
        int dens;
        int r;
        int c;
        style = $urandom_range(3);
        dens = $urandom_range(20, 80);
        for (r = 0; r < h; r++)
            for (c = 0; c < w; c++)
                img[r][c] = (style == 0) ? ($urandom_range(99) < dens) : 1'b0;
        if (style != 0 && w > 1 && h > 1)
        begin
            repeat ($urandom_range(1, (w * h) / 3 + 1))
            begin
                r = $urandom_range(h - 2);
                c = $urandom_range(w - 2);
                img[r][c] = 1'b1;
                img[r][c+1] = 1'b1;
                img[r+1][c] = 1'b1;
                img[r+1][c+1] = 1'b1;
            end
        end
        if (style == 3)
        begin
            repeat ($urandom_range(1, 2))
            begin
                r = $urandom_range(h - 1);
                c = $urandom_range(w - 1);
                img[r][c] = !img[r][c];
            end
        end
    endtask

    task automatic push_frame(input int w, input int keep, input int settle_at);
        for (int k = 0; k < keep; k++)
            pixel_q.push_back('{value: img[k / w][k % w],
                                settle_first: (k == settle_at) || ($urandom_range(199) == 0)});
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(29))
            0: return DIM_W'(0);
            1: return DIM_W'(127);
            2: return DIM_W'(64);
            3: return DIM_W'(65);
            4: return DIM_W'(1);
            default: return DIM_W'($urandom_range(2, 7));
        endcase
    endfunction

    initial
    begin : stimulus
        int random_px;
        int phase_n;
        int frames;
        int keep;
        int w;
        int h;
        logic [DIM_W-1:0] wraw;
        logic [DIM_W-1:0] hraw;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A filled square, a broken one and an empty one.
        cfg_write(CFG_FRAME_WIDTH, DIM_W'(2));
        cfg_write(CFG_FRAME_HEIGHT, DIM_W'(2));
        send_bits(12, 12'b1111_1011_0000);
        wait_idle();
        // Zero sizes act as single pixels.
        cfg_write(CFG_FRAME_WIDTH, DIM_W'(0));
        cfg_write(CFG_FRAME_HEIGHT, DIM_W'(0));
        send_bits(2, 2'b10);
        wait_idle();
        // A write to an unused index must not disturb the frame in progress.
        cfg_write(CFG_FRAME_WIDTH, DIM_W'(3));
        cfg_write(CFG_FRAME_HEIGHT, DIM_W'(3));
        send_bits(5, 5'b110_11);
        wait_idle();
        cfg_write(CFG_SPARE, DIM_W'(127));
        send_bits(4, 4'b0_001);
        wait_idle();
        // Oversized height, abandoned part way; the next write restarts the frame.
        cfg_write(CFG_FRAME_WIDTH, DIM_W'(3));
        cfg_write(CFG_FRAME_HEIGHT, DIM_W'(127));
        send_bits(4, 4'b1111);

        random_px = 0;
        phase_n = 0;
        while (random_px < 250)
        begin
            wait_idle();
            if (phase_n == 0)
            begin
                wraw = DIM_W'(64);
                hraw = DIM_W'(2);
            end
            else
            begin
                wraw = pick_dim();
                hraw = pick_dim();
                if (eff_dim(wraw, MAX_WIDTH) * eff_dim(hraw, MAX_HEIGHT) > 130)
                    hraw = DIM_W'($urandom_range(1, 2));
            end
            if ($urandom_range(1))
            begin
                cfg_write(CFG_FRAME_WIDTH, wraw);
                cfg_write(CFG_FRAME_HEIGHT, hraw);
            end
            else
            begin
                cfg_write(CFG_FRAME_HEIGHT, hraw);
                cfg_write(CFG_FRAME_WIDTH, wraw);
            end
            w = eff_dim(wraw, MAX_WIDTH);
            h = eff_dim(hraw, MAX_HEIGHT);
            sender_steady = (phase_n == 0) || ($urandom_range(3) == 0);
            receiver_steady = ($urandom_range(3) == 0);
            // The first phase backs up the result side while pixels keep coming.
            if (phase_n == 0)
                hold_req = 120;
            frames = (w * h <= 16) ? $urandom_range(1, 4) : 1;
            for (int f = 0; f < frames; f++)
            begin
                build_frame(w, h);
                keep = w * h;
                if (phase_n != 0 && f == frames - 1 && keep > 1 && $urandom_range(6) == 0)
                    keep = $urandom_range(1, keep - 1);
                push_frame(w, keep, (phase_n == 0) ? 100 : -1);
                random_px += keep;
            end
            phase_n++;
        end

        while (pixel_q.size() != 0 || pix_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d pixels, %0d results and %0d register writes.",
                 pixels_sent, results_seen, cfg_writes);
        $display("Frames closed: %0d, %0d equal to their opening; %0d anchors reported.",
                 frames_closed, frames_clean, anchors_seen);
        if (mismatches == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
